FILE: rtl/assert_macros.svh
// assertion macros for the rtl top level, the one rtl file that carries checks
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/srl_pkg.sv
// types, codes and helpers for the s-record loader parser
// no dependencies; imported by every module of the block
package srl_pkg;

   // parser phase, one-hot
   typedef enum logic [7:0] {
      PH_START = 8'b0000_0001,
      PH_TYPE  = 8'b0000_0010,
      PH_COUNT = 8'b0000_0100,
      PH_ADDR  = 8'b0000_1000,
      PH_DATA  = 8'b0001_0000,
      PH_CHECK = 8'b0010_0000,
      PH_TAIL  = 8'b0100_0000,
      PH_SKIP  = 8'b1000_0000
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_FIRST = 3'd1,
      ST_HEX   = 3'd2,
      ST_RANGE = 3'd3,
      ST_SUM   = 3'd4,
      ST_TYPE  = 3'd5
   } status_type;

   // record type digits, as value of the character minus '0'
   localparam logic [7:0] REC_HDR = 8'd0;
   localparam logic [7:0] REC_D16 = 8'd1;
   localparam logic [7:0] REC_D24 = 8'd2;
   localparam logic [7:0] REC_D32 = 8'd3;
   localparam logic [7:0] REC_CNT = 8'd5;
   localparam logic [7:0] REC_E32 = 8'd7;
   localparam logic [7:0] REC_E24 = 8'd8;
   localparam logic [7:0] REC_E16 = 8'd9;

   localparam logic [2:0] ADDR_BYTES_16 = 3'd2;
   localparam logic [2:0] ADDR_BYTES_24 = 3'd3;
   localparam logic [2:0] ADDR_BYTES_32 = 3'd4;

   localparam logic [7:0] CHAR_S       = 8'h53;
   localparam logic [7:0] CHAR_NL      = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UP_A    = 8'h41;
   localparam logic [7:0] CHAR_UP_F    = 8'h46;
   localparam logic [7:0] CHAR_LO_A    = 8'h61;
   localparam logic [7:0] CHAR_LO_F    = 8'h66;
   localparam logic [7:0] CHAR_SEVEN   = 8'h37;
   localparam logic [7:0] CHAR_LO_BIAS = 8'h57;   // 'a' - 10

   localparam logic [7:0]  SUM_GOOD      = 8'hFF;
   localparam logic [31:0] MEM_SIZE_RST  = 32'd65536;

   // one result as produced by the parser
   typedef struct packed {
      logic        write_enable;
      logic [31:0] write_address;
      logic [7:0]  write_data;
      logic        record_done;
      status_type  status;
      logic [31:0] extent;
   } result_type;

   // parser state seen by the top level
   typedef struct packed {
      phase_type   phase;
      logic [8:0]  bytes_left;
      status_type  sticky;
      logic [31:0] extent;
   } view_type;

   // hex digit decode: bit 4 set when the character is no hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd16;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) v = c - CHAR_ZERO;
      else if (c >= CHAR_UP_A && c <= CHAR_UP_F) v = c - CHAR_SEVEN;
      else if (c >= CHAR_LO_A && c <= CHAR_LO_F) v = c - CHAR_LO_BIAS;
      return v[4:0];
   endfunction

endpackage

FILE: rtl/srl_parser.sv
// per-character parser state and next-state logic of the s-record loader
// depends on srl_pkg
module srl_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          character,
   input  logic [31:0]         memory_size,
   output srl_pkg::result_type result,
   output srl_pkg::view_type   view
);
   import srl_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [8:0]  bytes_left_ff, bytes_left_in;
   logic [2:0]  addr_left_ff, addr_left_in;
   logic [31:0] load_addr_ff, load_addr_in;
   logic [7:0]  sum_ff, sum_in;
   logic [3:0]  high_nib_ff, high_nib_in;
   logic        nib_pend_ff, nib_pend_in;
   status_type  sticky_ff, sticky_in;
   logic [31:0] extent_ff, extent_in;

   logic [4:0]  hex;
   logic [7:0]  type_digit;
   logic [7:0]  byte_val;
   logic [7:0]  sum_plus;
   logic [7:0]  count_min;
   logic [31:0] addr_shift;
   logic [32:0] range_end;
   logic [31:0] addr_inc;

   always_comb begin
      hex        = hex_value(character);
      type_digit = character - CHAR_ZERO;
      byte_val   = {high_nib_ff, hex[3:0]};
      sum_plus   = sum_ff + byte_val;
      count_min  = {5'd0, addr_left_ff} + 8'd1;
      addr_shift = {load_addr_ff[23:0], byte_val};
      range_end  = {1'b0, addr_shift} + {24'd0, bytes_left_ff};
      addr_inc   = load_addr_ff + 32'd1;
   end

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      addr_left_in  = addr_left_ff;
      load_addr_in  = load_addr_ff;
      sum_in        = sum_ff;
      high_nib_in   = high_nib_ff;
      nib_pend_in   = nib_pend_ff;
      sticky_in     = sticky_ff;
      extent_in     = extent_ff;
      result        = '0;
      if (sticky_ff == ST_OK) begin
         unique case (phase_ff)
            PH_START: begin
               if (character == CHAR_S) phase_in = PH_TYPE;
               else sticky_in = ST_FIRST;
            end
            PH_TYPE: begin
               nib_pend_in  = 1'b0;
               load_addr_in = '0;
               unique case (type_digit) inside
                  REC_D16, REC_E16: begin
                     addr_left_in = ADDR_BYTES_16;
                     phase_in     = PH_COUNT;
                  end
                  REC_D24, REC_E24: begin
                     addr_left_in = ADDR_BYTES_24;
                     phase_in     = PH_COUNT;
                  end
                  REC_D32, REC_E32: begin
                     addr_left_in = ADDR_BYTES_32;
                     phase_in     = PH_COUNT;
                  end
                  REC_HDR, REC_CNT: phase_in = PH_SKIP;
                  default: sticky_in = ST_TYPE;
               endcase
            end
            PH_TAIL, PH_SKIP: begin
               if (character == CHAR_NL) begin
                  result.record_done = 1'b1;
                  phase_in           = PH_START;
               end
            end
            PH_COUNT, PH_ADDR, PH_DATA, PH_CHECK: begin
               if (hex[4]) begin
                  sticky_in = ST_HEX;
               end else if (!nib_pend_ff) begin
                  high_nib_in = hex[3:0];
                  nib_pend_in = 1'b1;
               end else begin
                  nib_pend_in = 1'b0;
                  sum_in      = sum_plus;
                  unique case (phase_ff)
                     PH_COUNT: begin
                        sum_in = byte_val;
                        if (byte_val < count_min) begin
                           sticky_in = ST_RANGE;
                        end else begin
                           bytes_left_in = {1'b0, byte_val - count_min};
                           phase_in      = PH_ADDR;
                        end
                     end
                     PH_ADDR: begin
                        load_addr_in = addr_shift;
                        addr_left_in = addr_left_ff - 3'd1;
                        // last address byte: check the whole record fits
                        if (addr_left_ff == 3'd1) begin
                           if (range_end > {1'b0, memory_size}) sticky_in = ST_RANGE;
                           else if (bytes_left_ff == 9'd0) phase_in = PH_CHECK;
                           else phase_in = PH_DATA;
                        end
                     end
                     PH_DATA: begin
                        result.write_enable  = 1'b1;
                        result.write_address = load_addr_ff;
                        result.write_data    = byte_val;
                        if (addr_inc > extent_ff) extent_in = addr_inc;
                        load_addr_in  = addr_inc;
                        bytes_left_in = bytes_left_ff - 9'd1;
                        if (bytes_left_ff == 9'd1) phase_in = PH_CHECK;
                     end
                     default: begin
                        if (sum_plus != SUM_GOOD) sticky_in = ST_SUM;
                        else phase_in = PH_TAIL;
                     end
                  endcase
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
      result.status = sticky_in;
      result.extent = extent_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         bytes_left_ff <= '0;
         addr_left_ff  <= '0;
         load_addr_ff  <= '0;
         sum_ff        <= '0;
         high_nib_ff   <= '0;
         nib_pend_ff   <= 1'b0;
         sticky_ff     <= ST_OK;
         extent_ff     <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         addr_left_ff  <= addr_left_in;
         load_addr_ff  <= load_addr_in;
         sum_ff        <= sum_in;
         high_nib_ff   <= high_nib_in;
         nib_pend_ff   <= nib_pend_in;
         sticky_ff     <= sticky_in;
         extent_ff     <= extent_in;
      end
   end

   assign view.phase      = phase_ff;
   assign view.bytes_left = bytes_left_ff;
   assign view.sticky     = sticky_ff;
   assign view.extent     = extent_ff;

endmodule

FILE: rtl/srl_out_stage.sv
// result register and handshake of the s-record loader
// depends on srl_pkg
module srl_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  srl_pkg::result_type in_result,
   output logic                out_valid,
   input  logic                out_ready,
   output srl_pkg::result_type out_result
);
   import srl_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;
   logic       load;

   // the register frees up in the same cycle its content is taken
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) valid_in = 1'b1;
      else if (out_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= in_result;
   end

   assign out_valid  = valid_ff;
   assign out_result = data_ff;

endmodule

FILE: rtl/srecord_loader_parser_core.sv
// top level of the s-record loader parser: csr register, parser, result stage
// depends on srl_pkg, srl_parser, srl_out_stage and assert_macros.svh
//
//  channel   dir  handshake              payload
//  req_      in   req_tvalid/req_tready  tdata: character
//  rsp_      out  rsp_tvalid/rsp_tready  tdata: address, data, status, extent;
//                                        tuser: write enable; tlast: record done
//  csr_      in   csr_wen                csr_wdata: memory size
//
// one result per character, one character per cycle sustained while rsp_tready stays high
// a character accepted at an edge has its result registered and shown right after that edge
// the single result register sets the rate; it is refilled in the cycle it drains
// reset: synchronous, clears parser state, sticky error, extent; memory size 65536
// a stalled rsp_tready holds the result and drops req_tready until taken
`include "assert_macros.svh"

module srecord_loader_parser_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] character
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,    // [31:0] write_address, [39:32] write_data,
                                     // [42:40] status, [74:43] extent, rest zero
   output logic        rsp_tuser,    // [0] write_enable
   output logic        rsp_tlast,    // record_done
   // configuration
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata     // memory_size
);
   import srl_pkg::*;

   logic [31:0] mem_size_ff;
   logic        step;
   result_type  step_result;
   result_type  rsp_result;
   view_type    view;

   // destination memory size; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) mem_size_ff <= MEM_SIZE_RST;
      else if (csr_wen) mem_size_ff <= csr_wdata;
   end

   // a request advances the parser exactly when it enters the result register
   assign step = req_tvalid && req_tready;

   srl_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .character   (req_tdata),
      .memory_size (mem_size_ff),
      .result      (step_result),
      .view        (view)
   );

   srl_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_result  (step_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   // pack the result fields, lowest first
   assign rsp_tdata = {5'd0,
                       rsp_result.extent,
                       rsp_result.status,
                       rsp_result.write_data,
                       rsp_result.write_address};
   assign rsp_tuser = rsp_result.write_enable;
   assign rsp_tlast = rsp_result.record_done;

   // an error once raised never changes until reset
   `ASSERT_NEXT(a_sticky_holds, clock, reset, view.sticky != ST_OK, view.sticky == $past(view.sticky))
   // a shown write never carries an error status
   `ASSERT_IMPLIES(a_write_ok, clock, reset, rsp_tvalid && rsp_tuser, rsp_result.status == ST_OK)
   // the data phase always has at least one byte outstanding
   `ASSERT_IMPLIES(a_data_left, clock, reset, view.phase == PH_DATA, view.bytes_left != 9'd0)
   // extent only grows
   `ASSERT_NEXT(a_extent_grows, clock, reset, !reset, view.extent >= $past(view.extent))

endmodule

FILE: dv/tb.sv
// testbench for srecord_loader_parser_core: feeds s-record text one character per request
// and checks every write, record end, status and extent against an in-bench line parser
// depends on srl_pkg and the rtl top level
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import srl_pkg::*;

   typedef enum logic [1:0] {CASE_UPPER, CASE_LOWER, CASE_MIXED} digit_case_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wen = 1'b0;
   logic [31:0] csr_wdata = '0;

   srecord_loader_parser_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // line parser state, starts where the block comes out of reset
   phase_type   ld_phase      = PH_START;
   logic [2:0]  ld_addr_left  = '0;
   logic [8:0]  ld_bytes_left = '0;
   logic [31:0] ld_next_addr  = '0;
   logic [7:0]  ld_sum        = '0;
   logic [3:0]  ld_hi         = '0;
   logic        ld_half       = 1'b0;
   status_type  ld_err        = ST_OK;
   logic [31:0] ld_extent     = '0;
   logic [31:0] ld_mem_size   = MEM_SIZE_RST;

   // outputs predicted for accepted characters, oldest first
   result_type  results_due[$];
   int          mismatches = 0;
   int          chars_sent = 0;
   int          req_calm = 0;
   int          rsp_calm = 0;
   digit_case_type digit_case = CASE_UPPER;

   // hex digit value, bit 4 set for anything else
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return 5'(c - CHAR_ZERO);
      if (c >= CHAR_UP_A && c <= CHAR_UP_F) return 5'(c - CHAR_UP_A + 10);
      if (c >= CHAR_LO_A && c <= CHAR_LO_F) return 5'(c - CHAR_LO_A + 10);
      return 5'd16;
   endfunction

   // advances the line parser by one character and returns the output it must show
   function automatic result_type parse_char(input logic [7:0] c);
      result_type  r;
      logic [4:0]  h;
      logic [7:0]  b;
      logic [7:0]  t;
      logic [32:0] span;
      r = '0;
      if (ld_err == ST_OK) begin
         case (ld_phase)
            PH_START: begin
               if (c == CHAR_S) ld_phase = PH_TYPE;
               else ld_err = ST_FIRST;
            end
            PH_TYPE: begin
               t = c - CHAR_ZERO;
               ld_half = 1'b0;
               ld_next_addr = '0;
               case (t)
                  REC_D16, REC_E16: begin
                     ld_addr_left = ADDR_BYTES_16;
                     ld_phase = PH_COUNT;
                  end
                  REC_D24, REC_E24: begin
                     ld_addr_left = ADDR_BYTES_24;
                     ld_phase = PH_COUNT;
                  end
                  REC_D32, REC_E32: begin
                     ld_addr_left = ADDR_BYTES_32;
                     ld_phase = PH_COUNT;
                  end
                  REC_HDR, REC_CNT: ld_phase = PH_SKIP;
                  default: ld_err = ST_TYPE;
               endcase
            end
            PH_TAIL, PH_SKIP: begin
               if (c == CHAR_NL) begin
                  r.record_done = 1'b1;
                  ld_phase = PH_START;
               end
            end
            default: begin
               h = nibble_of(c);
               if (h[4]) begin
                  ld_err = ST_HEX;
               end else if (!ld_half) begin
                  ld_hi = h[3:0];
                  ld_half = 1'b1;
               end else begin
                  b = {ld_hi, h[3:0]};
                  ld_half = 1'b0;
                  ld_sum = (ld_phase == PH_COUNT) ? b : ld_sum + b;
                  case (ld_phase)
                     PH_COUNT: begin
                        if (b < ld_addr_left + 1) begin
                           ld_err = ST_RANGE;
                        end else begin
                           ld_bytes_left = 9'(b - ld_addr_left - 1);
                           ld_phase = PH_ADDR;
                        end
                     end
                     PH_ADDR: begin
                        ld_next_addr = {ld_next_addr[23:0], b};
                        ld_addr_left = ld_addr_left - 3'd1;
                        if (ld_addr_left == 0) begin
                           span = {1'b0, ld_next_addr} + 33'(ld_bytes_left);
                           if (span > {1'b0, ld_mem_size}) ld_err = ST_RANGE;
                           else ld_phase = (ld_bytes_left == 0) ? PH_CHECK : PH_DATA;
                        end
                     end
                     PH_DATA: begin
                        r.write_enable = 1'b1;
                        r.write_address = ld_next_addr;
                        r.write_data = b;
                        if (ld_next_addr + 32'd1 > ld_extent) ld_extent = ld_next_addr + 32'd1;
                        ld_next_addr = ld_next_addr + 32'd1;
                        ld_bytes_left = ld_bytes_left - 9'd1;
                        if (ld_bytes_left == 0) ld_phase = PH_CHECK;
                     end
                     default: begin
                        if (ld_sum != SUM_GOOD) ld_err = ST_SUM;
                        else ld_phase = PH_TAIL;
                     end
                  endcase
               end
            end
         endcase
      end
      r.status = ld_err;
      r.extent = ld_extent;
      return r;
   endfunction

   // idle cycles before the next request or result, with runs of back-to-back traffic
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         calm = $urandom_range(8, 64);
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   function automatic int addr_len(input logic [7:0] rtype);
      case (rtype)
         REC_D16, REC_E16: return int'(ADDR_BYTES_16);
         REC_D24, REC_E24: return int'(ADDR_BYTES_24);
         default:          return int'(ADDR_BYTES_32);
      endcase
   endfunction

   function automatic logic [7:0] pick_load_type();
      case ($urandom_range(0, 5))
         0:       return REC_D16;
         1:       return REC_D24;
         2:       return REC_D32;
         3:       return REC_E16;
         4:       return REC_E24;
         default: return REC_E32;
      endcase
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] n);
      logic lower;
      lower = (digit_case == CASE_LOWER) ||
              (digit_case == CASE_MIXED && $urandom_range(0, 1) == 1);
      if (n < 10) return CHAR_ZERO + 8'(n);
      return 8'((lower ? CHAR_LO_A : CHAR_UP_A) + n - 10);
   endfunction

   function automatic logic [7:0] any_but_newline();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_NL);
      return c;
   endfunction

   // one character request; the prediction is made at the edge that takes it
   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      results_due.push_back(parse_char(c));
      chars_sent++;
   endtask

   // builds one record line; count_fix, sum_xor and bad_at spoil it on purpose
   task automatic send_record(input logic [7:0] rtype, input logic [31:0] addr,
                              input int ndata, input int count_fix,
                              input logic [7:0] sum_xor, input int bad_at);
      logic [7:0] fields[$];
      logic [7:0] text[$];
      logic [7:0] total;
      logic [7:0] c;
      int         alen;
      alen = addr_len(rtype);
      fields.push_back((count_fix >= 0) ? 8'(count_fix) : 8'(ndata + alen + 1));
      for (int i = alen - 1; i >= 0; i--) fields.push_back(addr[8*i +: 8]);
      repeat (ndata) fields.push_back(8'($urandom));
      total = '0;
      foreach (fields[i]) total += fields[i];
      fields.push_back(~total ^ sum_xor);
      text.push_back(CHAR_S);
      text.push_back(CHAR_ZERO + rtype);
      foreach (fields[i]) begin
         text.push_back(digit_char(fields[i][7:4]));
         text.push_back(digit_char(fields[i][3:0]));
      end
      if (bad_at >= 0) begin
         do c = 8'($urandom_range(0, 255)); while (nibble_of(c) < 5'd16);
         text[2 + bad_at] = c;
      end
      // free text after the checksum
      repeat ($urandom_range(0, 3)) text.push_back(any_but_newline());
      text.push_back(CHAR_NL);
      foreach (text[i]) send_char(text[i]);
   endtask

   task automatic send_good(input logic [7:0] rtype, input logic [31:0] addr, input int ndata);
      send_record(rtype, addr, ndata, -1, 8'h00, -1);
   endtask

   // header or count line, its body is never looked at
   task automatic send_skip(input logic [7:0] rtype);
      send_char(CHAR_S);
      send_char(CHAR_ZERO + rtype);
      repeat ($urandom_range(0, 12)) send_char(any_but_newline());
      send_char(CHAR_NL);
   endtask

   // legal record that fits the current memory size, often right at its end
   task automatic send_random_record(input logic [7:0] rtype);
      longint unsigned top;
      longint unsigned span_max;
      int              alen;
      int              n;
      logic [31:0]     addr;
      alen = addr_len(rtype);
      n = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 254 - alen) : $urandom_range(0, 12);
      if (n > ld_mem_size) n = int'(ld_mem_size);
      span_max = (64'd1 << (8 * alen)) - 1;
      top = 64'(ld_mem_size) - 64'(n);
      if (top > span_max) top = span_max;
      case ($urandom_range(0, 7))
         0, 1:    addr = 32'(top);
         2:       addr = '0;
         default: addr = 32'(64'($urandom) % (top + 1));
      endcase
      send_good(rtype, addr, n);
   endtask

   // stop sending and let every predicted output come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // memory size only changes while the parser has nothing in flight
   task automatic set_memory_size(input logic [31:0] size);
      wait_drained();
      csr_wen   <= 1'b1;
      csr_wdata <= size;
      @(posedge clock);
      csr_wen   <= 1'b0;
      ld_mem_size = size;
   endtask

   // every record type, lower case digits, empty data, skipped lines with odd bytes
   task automatic test_plain_records();
      send_good(REC_D16, 32'h0000, 1);
      send_good(REC_D24, 32'h000020, 0);
      digit_case = CASE_LOWER;
      send_good(REC_D32, 32'h0000_003c, 4);
      digit_case = CASE_MIXED;
      send_char(CHAR_S);
      send_char(CHAR_ZERO + REC_HDR);
      send_char(8'h00);
      send_char(8'hFF);
      send_char(CHAR_S);
      send_char(CHAR_NL);
      send_skip(REC_CNT);
      digit_case = CASE_UPPER;
      send_good(REC_E16, 32'h0100, 0);
      send_good(REC_E24, 32'h000200, 2);
      send_good(REC_E32, 32'h0000_0300, 0);
   endtask

   // tiny memories, records that end exactly at the last byte
   task automatic test_small_memory();
      set_memory_size(32'd0);
      send_good(REC_D16, 32'h0, 0);
      send_good(REC_E32, 32'h0, 0);
      set_memory_size(32'd1);
      send_good(REC_D24, 32'h0, 1);
      set_memory_size(32'd300);
      send_good(REC_D32, 32'd296, 4);
   endtask

   // random legal lines; memory size redrawn now and then, wider near the end
   task automatic test_random_stream();
      int start;
      int recs;
      logic [31:0] size;
      start = chars_sent;
      recs = 0;
      while (chars_sent - start < 1550) begin
         if (recs % 12 == 11) begin
            case ($urandom_range(0, (chars_sent - start > 1150) ? 5 : 3))
               0:       size = 32'd0;
               1:       size = 32'd1;
               2:       size = MEM_SIZE_RST;
               3:       size = ld_extent + 32'($urandom_range(0, 8192));
               4:       size = 32'hFFFF_FFFF;
               default: size = $urandom;
            endcase
            set_memory_size(size);
         end else if ($urandom_range(0, 19) == 0) begin
            wait_drained();
         end
         digit_case = digit_case_type'($urandom_range(CASE_UPPER, CASE_MIXED));
         if ($urandom_range(0, 7) == 0) send_skip($urandom_range(0, 1) ? REC_HDR : REC_CNT);
         else send_random_record(pick_load_type());
         recs++;
      end
   endtask

   // writes at the very top of a full 32-bit memory
   task automatic test_top_of_memory();
      set_memory_size(32'hFFFF_FFFF);
      send_good(REC_D32, 32'hFFFF_FFFE, 1);
      send_good(REC_E32, 32'hFFFF_FFFF, 0);
   endtask

   // one error per run, picked at random, then text that must all be ignored
   task automatic test_sticky_error();
      status_type fault;
      logic [7:0] c;
      logic [7:0] t;
      logic [7:0] rtype;
      int         n;
      int         alen;
      set_memory_size(32'($urandom_range(0, 512)));
      digit_case = CASE_MIXED;
      rtype = pick_load_type();
      alen = addr_len(rtype);
      n = $urandom_range(0, 6);
      if (n > ld_mem_size) n = int'(ld_mem_size);
      fault = status_type'($urandom_range(ST_FIRST, ST_TYPE));
      case (fault)
         ST_FIRST: begin
            if ($urandom_range(0, 2) == 0) c = CHAR_NL;
            else do c = 8'($urandom_range(0, 255)); while (c == CHAR_S);
            send_char(c);
         end
         ST_TYPE: begin
            if ($urandom_range(0, 3) == 0) begin
               c = CHAR_NL;
            end else begin
               do begin
                  c = 8'($urandom_range(0, 255));
                  t = c - CHAR_ZERO;
               end while (t inside {REC_HDR, REC_D16, REC_D24, REC_D32,
                                    REC_CNT, REC_E32, REC_E24, REC_E16});
            end
            send_char(CHAR_S);
            send_char(c);
         end
         ST_HEX: send_record(rtype, 32'h0, n, -1, 8'h00, $urandom_range(0, 2 * (alen + n + 2) - 1));
         ST_RANGE: begin
            // either a count too short for the address, or a record running off the end
            if ($urandom_range(0, 1)) send_record(rtype, 32'h0, n, $urandom_range(0, alen), 8'h00, -1);
            else send_good(REC_D24, ld_mem_size + 1 + 32'($urandom_range(0, 4)), n);
         end
         default: send_record(rtype, 32'h0, n, -1, 8'($urandom_range(1, 255)), -1);
      endcase
      repeat (2) send_random_record(pick_load_type());
      repeat (24) send_char(8'($urandom_range(0, 255)));
   endtask

   // result side: a random stall before each result, then take it
   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // compare every taken result with the oldest prediction
   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.write_enable  = rsp_tuser;
         seen.write_address = rsp_tdata[31:0];
         seen.write_data    = rsp_tdata[39:32];
         seen.record_done   = rsp_tlast;
         seen.status        = status_type'(rsp_tdata[42:40]);
         seen.extent        = rsp_tdata[74:43];
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("%0t: result with no request pending", $time);
         end else begin
            want = results_due.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: expected we=%0b addr=%h data=%h done=%0b status=%0d extent=%h",
                           $time, want.write_enable, want.write_address, want.write_data,
                           want.record_done, want.status, want.extent);
                  $display("%0t: actual   we=%0b addr=%h data=%h done=%0b status=%0d extent=%h",
                           $time, seen.write_enable, seen.write_address, seen.write_data,
                           seen.record_done, seen.status, seen.extent);
               end
            end
         end
      end
   end

   // main sequence: reset once, then each test in turn
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_plain_records();
      test_small_memory();
      test_random_stream();
      test_top_of_memory();
      test_sticky_error();
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && results_due.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #6_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/srl_pkg.sv
rtl/srl_parser.sv
rtl/srl_out_stage.sv
rtl/srecord_loader_parser_core.sv
dv/tb.sv
